@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the fader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define AST_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define AST_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rlf_pkg.sv @@
`timescale 1ns / 1ps

package rlf_pkg;

  localparam int unsigned COLOR_MAX_DEFAULT = 1023;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned INC_W   = 9;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned LED_W   = 10;
  localparam int unsigned PHASE_W = 3;

  localparam logic [INC_W-1:0]  INC_RESET   = 9'd25;
  localparam logic [STEP_W-1:0] LIMIT_RESET = 10'd500;

  localparam logic REG_STEP_INCREMENT = 1'b0;
  localparam logic REG_STEP_LIMIT     = 1'b1;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam logic [PHASE_W-1:0] PH_G_UP = 3'd0;
  localparam logic [PHASE_W-1:0] PH_R_DN = 3'd1;
  localparam logic [PHASE_W-1:0] PH_B_UP = 3'd2;
  localparam logic [PHASE_W-1:0] PH_G_DN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_R_UP = 3'd4;
  localparam logic [PHASE_W-1:0] PH_B_DN = 3'd5;

  typedef struct packed {
    logic [INC_W-1:0]  step_increment;
    logic [STEP_W-1:0] step_limit;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic              button_up;
    logic              button_down;
    logic [STEP_W-1:0] step_value;
  } item_t;

  typedef struct packed {
    logic [LED_W-1:0]  red;
    logic [LED_W-1:0]  green;
    logic [LED_W-1:0]  blue;
    logic [STEP_W-1:0] step_now;
    logic              accepted;
  } result_t;

endpackage

@@ hw/rtl/rainbow_led_fader.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    func, button_up, button_down, step_value
// out       out  out_valid / out_ready  red, green, blue, step_now, accepted
// cfg       in   psel / penable         pwrite, paddr, pwdata, prdata, pready
//
// One beat per cycle sustained while out_ready is high. The input register feeds
// the wheel logic, which updates state and the result register in the same edge.
// A stalled result register backs up the input register, then in_ready drops.
// Reset is synchronous; no clearing pass.

`include "assert_macros.svh"

module rainbow_led_fader #(
  parameter int unsigned COLOR_MAX = rlf_pkg::COLOR_MAX_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic                        button_up,
  input  logic                        button_down,
  input  logic [rlf_pkg::STEP_W-1:0]  step_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rlf_pkg::LED_W-1:0]   red,
  output logic [rlf_pkg::LED_W-1:0]   green,
  output logic [rlf_pkg::LED_W-1:0]   blue,
  output logic [rlf_pkg::STEP_W-1:0]  step_now,
  output logic                        accepted,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlf_pkg::ADDR_W-1:0]  paddr,
  input  logic [rlf_pkg::DATA_W-1:0]  pwdata,
  output logic [rlf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rlf_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid;
  logic    fire;
  result_t res;
  result_t res_q;

  rlf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlf_wheel #(
    .COLOR_MAX (COLOR_MAX)
  ) u_wheel (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.func        <= func;
      item_q.button_up   <= button_up;
      item_q.button_down <= button_down;
      item_q.step_value  <= step_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign red      = res_q.red;
  assign green    = res_q.green;
  assign blue     = res_q.blue;
  assign step_now = res_q.step_now;
  assign accepted = res_q.accepted;

  `AST_CLK_RST(a_empty_ready, clk, rst, !item_valid |-> in_ready, "empty but not ready")
  `AST_CLK_RST(a_fire_out, clk, rst, fire |=> out_valid, "beat lost before result")
  `AST_CLK_RST(a_full_stall, clk, rst, item_valid && !fire |-> !in_ready, "taken while full")
  `AST_CLK(a_rst_clear, clk, $past(rst) |-> (!out_valid && !item_valid), "reset left valid set")

endmodule

@@ hw/rtl/rlf_cfg.sv @@
`timescale 1ns / 1ps

module rlf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rlf_pkg::ADDR_W-1:0]   paddr,
  input  logic [rlf_pkg::DATA_W-1:0]   pwdata,
  output logic [rlf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output rlf_pkg::cfg_t                cfg
);
  import rlf_pkg::*;

  logic reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_increment <= INC_RESET;
      cfg.step_limit     <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_STEP_INCREMENT: cfg.step_increment <= pwdata[INC_W-1:0];
        REG_STEP_LIMIT:     cfg.step_limit     <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STEP_INCREMENT: prdata = DATA_W'(cfg.step_increment);
      REG_STEP_LIMIT:     prdata = DATA_W'(cfg.step_limit);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/rlf_wheel.sv @@
`timescale 1ns / 1ps

module rlf_wheel #(
  parameter int unsigned COLOR_MAX = rlf_pkg::COLOR_MAX_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  rlf_pkg::item_t    item,
  input  rlf_pkg::cfg_t     cfg,
  output rlf_pkg::result_t  res
);
  import rlf_pkg::*;

  localparam int unsigned LW = $clog2(COLOR_MAX + 1);
  localparam int unsigned AW = (LW > STEP_W) ? LW : STEP_W;
  localparam int unsigned SW = AW + 1;
  localparam logic [LW-1:0] LVL_MAX = LW'(COLOR_MAX);
  localparam logic [SW-1:0] SUM_MAX = SW'(COLOR_MAX);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [LW-1:0]      red_level, red_level_next;
  logic [LW-1:0]      green_level, green_level_next;
  logic [LW-1:0]      blue_level, blue_level_next;
  logic [STEP_W-1:0]  step_size, step_size_next;

  logic [LW-1:0]     sel_level;
  logic [LW-1:0]     moved;
  logic              up;
  logic              adv;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     diff;
  logic [STEP_W:0]   bump;
  logic [STEP_W-1:0] step_tmp;
  logic              step_on;

  function automatic logic [LED_W-1:0] to_led(input logic [LW-1:0] v);
    logic [AW-1:0] w;
    w = AW'(v);
    return w[LED_W-1:0];
  endfunction

  always_comb begin
    up        = 1'b0;
    sel_level = green_level;
    unique case (phase)
      PH_G_UP: begin sel_level = green_level; up = 1'b1; end
      PH_R_DN: begin sel_level = red_level;   up = 1'b0; end
      PH_B_UP: begin sel_level = blue_level;  up = 1'b1; end
      PH_G_DN: begin sel_level = green_level; up = 1'b0; end
      PH_R_UP: begin sel_level = red_level;   up = 1'b1; end
      PH_B_DN: begin sel_level = blue_level;  up = 1'b0; end
      default: begin sel_level = green_level; up = 1'b0; end
    endcase
    sum  = SW'(sel_level) + SW'(step_size);
    diff = SW'(sel_level) - SW'(step_size);
    if (up) begin
      if (sum >= SUM_MAX) begin
        moved = LVL_MAX;
        adv   = 1'b1;
      end else begin
        moved = sum[LW-1:0];
        adv   = 1'b0;
      end
    end else if (SW'(step_size) > SW'(sel_level) || diff >= SUM_MAX) begin
      moved = '0;
      adv   = 1'b1;
    end else begin
      moved = diff[LW-1:0];
      adv   = 1'b0;
    end
  end

  always_comb begin
    phase_next       = phase;
    red_level_next   = red_level;
    green_level_next = green_level;
    blue_level_next  = blue_level;
    step_size_next   = step_size;
    step_on          = (step_size != '0);
    bump             = '0;
    step_tmp         = step_size;
    res.accepted     = 1'b1;
    res.red          = '0;
    res.green        = '0;
    res.blue         = '0;

    if (item.func == FUNC_TICK) begin
      if (step_on) begin
        unique case (phase)
          PH_G_UP, PH_G_DN: green_level_next = moved;
          PH_R_DN, PH_R_UP: red_level_next   = moved;
          PH_B_UP, PH_B_DN: blue_level_next  = moved;
          default: ;
        endcase
        if (phase > PH_B_DN) begin
          phase_next = PH_G_UP;
        end else if (adv) begin
          phase_next = (phase == PH_B_DN) ? PH_G_UP : PHASE_W'(phase + 3'd1);
        end
        res.red   = to_led(red_level_next);
        res.green = to_led(green_level_next);
        res.blue  = to_led(blue_level_next);
      end
      if (item.button_up) begin
        bump     = {1'b0, step_size} + (STEP_W + 1)'(cfg.step_increment);
        step_tmp = (bump > {1'b0, cfg.step_limit}) ? cfg.step_limit : bump[STEP_W-1:0];
      end
      if (item.button_down) begin
        step_tmp = (STEP_W'(cfg.step_increment) > step_tmp) ? '0
                 : step_tmp - STEP_W'(cfg.step_increment);
      end
      step_size_next = step_tmp;
    end else begin
      if (item.step_value <= cfg.step_limit) begin
        step_size_next = item.step_value;
      end else begin
        res.accepted = 1'b0;
      end
      if (step_size_next != '0) begin
        res.red   = to_led(red_level);
        res.green = to_led(green_level);
        res.blue  = to_led(blue_level);
      end
    end
    res.step_now = step_size_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_G_UP;
      red_level   <= LVL_MAX;
      green_level <= '0;
      blue_level  <= '0;
      step_size   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      red_level   <= red_level_next;
      green_level <= green_level_next;
      blue_level  <= blue_level_next;
      step_size   <= step_size_next;
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rlf_pkg::*;

  localparam int unsigned LED_TOP = COLOR_MAX_DEFAULT;
  localparam int unsigned BEATS_PER_SETTING = 90;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_TICK;
  logic              button_up = 1'b0;
  logic              button_down = 1'b0;
  logic [STEP_W-1:0] step_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LED_W-1:0]  red;
  logic [LED_W-1:0]  green;
  logic [LED_W-1:0]  blue;
  logic [STEP_W-1:0] step_now;
  logic              accepted;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [PHASE_W-1:0] wheel_phase = PH_G_UP;
  logic [LED_W-1:0]   lvl_r = LED_TOP[LED_W-1:0];
  logic [LED_W-1:0]   lvl_g = '0;
  logic [LED_W-1:0]   lvl_b = '0;
  logic [STEP_W-1:0]  cur_step = '0;
  logic [INC_W-1:0]   cfg_inc = INC_RESET;
  logic [STEP_W-1:0]  cfg_limit = LIMIT_RESET;

  result_t  expected_leds [$];
  dir_row_t dir_rows [$];
  int       idle_run [2] = '{0, 0};
  int       mismatches = 0;
  int       beats_in = 0;
  int       beats_out = 0;
  int       wheel_wraps = 0;
  int       sets_rejected = 0;
  int       settings_run = 1;
  int       quiet_cycles = 0;

  rainbow_led_fader u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .button_up   (button_up),
    .button_down (button_down),
    .step_value  (step_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .step_now    (step_now),
    .accepted    (accepted),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  task automatic mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [LED_W:0] level_move(input int unsigned lvl,
                                                input int unsigned amt, input bit up);
    int unsigned v;
    if (up) begin
      v = lvl + amt;
      if (v >= LED_TOP) return {1'b1, LED_TOP[LED_W-1:0]};
      return {1'b0, v[LED_W-1:0]};
    end
    if (amt > lvl) return {1'b1, {LED_W{1'b0}}};
    v = lvl - amt;
    if (v >= LED_TOP) return {1'b1, {LED_W{1'b0}}};
    return {1'b0, v[LED_W-1:0]};
  endfunction

  function automatic result_t wheel_predict(input item_t it);
    result_t       r;
    logic [LED_W:0] mv;
    int unsigned   s;
    r.accepted = 1'b1;
    mv = '0;
    if (it.func == FUNC_TICK) begin
      if (cur_step != 0) begin
        case (wheel_phase)
          PH_G_UP: begin mv = level_move(lvl_g, cur_step, 1'b1); lvl_g = mv[LED_W-1:0]; end
          PH_R_DN: begin mv = level_move(lvl_r, cur_step, 1'b0); lvl_r = mv[LED_W-1:0]; end
          PH_B_UP: begin mv = level_move(lvl_b, cur_step, 1'b1); lvl_b = mv[LED_W-1:0]; end
          PH_G_DN: begin mv = level_move(lvl_g, cur_step, 1'b0); lvl_g = mv[LED_W-1:0]; end
          PH_R_UP: begin mv = level_move(lvl_r, cur_step, 1'b1); lvl_r = mv[LED_W-1:0]; end
          PH_B_DN: begin mv = level_move(lvl_b, cur_step, 1'b0); lvl_b = mv[LED_W-1:0]; end
          default: wheel_phase = PH_G_UP;
        endcase
        if (mv[LED_W]) begin
          if (wheel_phase == PH_B_DN) begin
            wheel_phase = PH_G_UP;
            wheel_wraps++;
          end else begin
            wheel_phase = wheel_phase + 1'b1;
          end
        end
        r.red = lvl_r;
        r.green = lvl_g;
        r.blue = lvl_b;
      end else begin
        r.red = '0;
        r.green = '0;
        r.blue = '0;
      end
      if (it.button_up) begin
        s = cur_step + cfg_inc;
        cur_step = (s > cfg_limit) ? cfg_limit : s[STEP_W-1:0];
      end
      if (it.button_down) cur_step = (cfg_inc > cur_step) ? '0 : cur_step - cfg_inc;
    end else begin
      if (it.step_value <= cfg_limit) begin
        cur_step = it.step_value;
      end else begin
        r.accepted = 1'b0;
        sets_rejected++;
      end
      r.red = (cur_step == 0) ? '0 : lvl_r;
      r.green = (cur_step == 0) ? '0 : lvl_g;
      r.blue = (cur_step == 0) ? '0 : lvl_b;
    end
    r.step_now = cur_step;
    return r;
  endfunction

  function automatic int pick_gap(input int side);
    int roll;
    if (idle_run[side] > 0) begin
      idle_run[side]--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      idle_run[side] = $urandom_range(15, 40);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    roll;
    it.func = ($urandom_range(0, 99) < 22) ? FUNC_SET : FUNC_TICK;
    it.button_up = ($urandom_range(0, 99) < 20);
    it.button_down = ($urandom_range(0, 99) < 15);
    roll = $urandom_range(0, 99);
    if (roll < 8) it.step_value = cfg_limit;
    else if (roll < 14) it.step_value = cfg_limit + 1'b1;
    else if (roll < 70) it.step_value = STEP_W'($urandom_range(0, cfg_limit));
    else it.step_value = STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
    return it;
  endfunction

  task automatic add_row(input logic f, input logic up, input logic dn, input int val,
                         input bit typed, input int r, input int g, input int b,
                         input int s, input int a);
    dir_row_t row;
    row.it.func = f;
    row.it.button_up = up;
    row.it.button_down = dn;
    row.it.step_value = STEP_W'(val);
    row.typed = typed;
    row.want.red = LED_W'(r);
    row.want.green = LED_W'(g);
    row.want.blue = LED_W'(b);
    row.want.step_now = STEP_W'(s);
    row.want.accepted = a[0];
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = pick_gap(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= it.func;
    button_up <= it.button_up;
    button_down <= it.button_down;
    step_value <= it.step_value;
    do @(posedge clk); while (!in_ready);
    pred = wheel_predict(it);
    expected_leds.push_back(typed ? want : pred);
    beats_in++;
  endtask

  task automatic reg_write(input logic idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_STEP_INCREMENT) cfg_inc = val[INC_W-1:0];
    else cfg_limit = val[STEP_W-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) mismatch("register readback", prdata, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // drive result-side backpressure
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap(1);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (expected_leds.size() == 0) begin
        mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = expected_leds.pop_front();
        if (red !== want.red) mismatch("red", red, want.red);
        if (green !== want.green) mismatch("green", green, want.green);
        if (blue !== want.blue) mismatch("blue", blue, want.blue);
        if (step_now !== want.step_now) mismatch("step_now", step_now, want.step_now);
        if (accepted !== want.accepted) mismatch("accepted", accepted, want.accepted);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_leds.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned plan_inc [6] = '{1, 500, 7, 500, 1, 0};
    int unsigned plan_lim [6] = '{1023, 1023, 100, 1, 1, 0};
    int unsigned inc_val;
    int unsigned lim_val;

    // after reset: step off, black output, set range checks
    add_row(FUNC_TICK, 0, 0,    0, 1,    0, 0, 0,   0, 1);
    add_row(FUNC_TICK, 0, 1,    0, 1,    0, 0, 0,   0, 1);
    add_row(FUNC_SET,  0, 0, 1023, 1,    0, 0, 0,   0, 0);
    add_row(FUNC_SET,  0, 0,    0, 1,    0, 0, 0,   0, 1);
    add_row(FUNC_TICK, 1, 0,    0, 1,    0, 0, 0,  25, 1);
    add_row(FUNC_SET,  0, 0,  500, 1, 1023, 0, 0, 500, 1);
    add_row(FUNC_SET,  0, 0,  501, 1, 1023, 0, 0, 500, 0);
    // exact thirds of full scale: green climbs, red lands on zero then clamps
    add_row(FUNC_SET,  1, 1,  341, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0, 1023, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,  682, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,    1, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 1, 1,  512, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SET,  0, 0,  490, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 1, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 1, 0,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 0, 1,    0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SET,  0, 0,    1, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_TICK, 1, 1,    0, 0, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      inc_val = (p == 5) ? $urandom_range(1, 500) : plan_inc[p];
      lim_val = (p == 5) ? $urandom_range(1, 1023) : plan_lim[p];
      drain_and_idle();
      reg_write(REG_STEP_INCREMENT, inc_val);
      reg_write(REG_STEP_LIMIT, lim_val);
      settings_run++;
      repeat (BEATS_PER_SETTING) send_beat(random_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_leds.size() != 0) mismatch("results never delivered", 0, expected_leds.size());

    $display("run: %0d input beats, %0d result beats over %0d register settings",
             beats_in, beats_out, settings_run);
    $display("run: %0d full color-wheel turns, %0d out-of-range step sets refused",
             wheel_wraps, sets_rejected);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rlf_pkg.sv
hw/rtl/rlf_cfg.sv
hw/rtl/rlf_wheel.sv
hw/rtl/rainbow_led_fader.sv
sim/tb_top.sv
